FILE: rtl/ttcq_pkg.sv
package ttcq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int MAX_RESULTS     = 16;

	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [1:0] KIND_ACCEPTED = 2'd0;
	localparam logic [1:0] KIND_FULL     = 2'd1;
	localparam logic [1:0] KIND_RELEASED = 2'd2;
	localparam logic [1:0] KIND_NONE_DUE = 2'd3;

	typedef struct packed {
		logic        valid;
		logic [31:0] time_tag;
		logic [7:0]  service;
		logic [7:0]  subservice;
		logic [15:0] command_tag;
	} entry_t;

	typedef struct packed {
		logic        insert;
		logic        pop;
		logic [31:0] cmp_time;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'b01,
		ST_RELEASE = 2'b10
	} state_t;

endpackage

FILE: rtl/ttcq_cell.sv
module ttcq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  ttcq_pkg::cell_cmd_t cmd,
	input  ttcq_pkg::entry_t   new_ent,
	input  ttcq_pkg::entry_t   left_ent,
	input  logic               left_le,
	input  ttcq_pkg::entry_t   right_ent,
	output ttcq_pkg::entry_t   ent,
	output logic               le
);
	import ttcq_pkg::*;

	logic        valid_q;
	logic [31:0] time_q;
	logic [7:0]  service_q;
	logic [7:0]  subservice_q;
	logic [15:0] tag_q;
	entry_t      next_ent;
	logic        load;

	// stored command is at or before the compare time
	assign le = valid_q && (time_q <= cmd.cmp_time);

	always_comb begin
		next_ent = ent;
		load     = 1'b0;
		if (cmd.pop) begin
			next_ent = right_ent;
			load     = 1'b1;
		end else if (cmd.insert && !le) begin
			load = 1'b1;
			// first cell after the run of earlier-or-equal entries takes the new command
			if (left_le) begin
				next_ent = new_ent;
			end else begin
				next_ent = left_ent;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= next_ent.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			time_q       <= next_ent.time_tag;
			service_q    <= next_ent.service;
			subservice_q <= next_ent.subservice;
			tag_q        <= next_ent.command_tag;
		end
	end

	assign ent = '{valid: valid_q, time_tag: time_q, service: service_q,
		subservice: subservice_q, command_tag: tag_q};

endmodule

FILE: rtl/time_tagged_command_queue.sv
// channel  dir  tdata                                        tuser      tlast
// s_*      in   time_value, service, subservice, command_tag operation  -
// m_*      out  out_time, out_service, out_subservice, out_tag kind       last
//
// on an insert every cell compares in parallel and the cells after the earlier-or-equal run shift right
// a release looks at the head when accepted, then makes one transfer per due command,
// each transfer popping the head of the cell chain; a none-due release gives one result
// reset empties the queue at once through the cell valid flags
// a stalled output holds the chain and no new transfer is taken meanwhile
module time_tagged_command_queue #(
	parameter int QUEUE_DEPTH = ttcq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // time_value, service, subservice, command_tag
	input  logic [0:0]  s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // out_time, out_service, out_subservice, out_tag
	output logic [1:0]  m_tuser,  // kind
	output logic        m_tlast   // last
);
	import ttcq_pkg::*;

	localparam int CW = $clog2(MAX_RESULTS + 1);

	state_t      state_q;
	logic        m_tvalid_q;
	logic [63:0] m_tdata_q;
	logic [1:0]  m_tuser_q;
	logic        m_tlast_q;
	logic [31:0] rel_time_q;
	logic [CW-1:0] cnt_q;

	entry_t    ent [QUEUE_DEPTH];
	logic      le  [QUEUE_DEPTH];
	entry_t    new_ent;
	cell_cmd_t cmd;
	logic      out_free;
	logic      s_acc;
	logic      full;
	logic      rel_last;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign s_acc    = s_tvalid && s_tready;
	assign full     = ent[QUEUE_DEPTH-1].valid;

	assign new_ent = '{valid: 1'b1, time_tag: s_tdata[31:0], service: s_tdata[39:32],
		subservice: s_tdata[47:40], command_tag: s_tdata[63:48]};

	assign cmd.cmp_time = (state_q == ST_RELEASE) ? rel_time_q : s_tdata[31:0];
	assign cmd.insert   = s_acc && (s_tuser[0] == OP_INSERT) && !full;
	assign cmd.pop      = (state_q == ST_RELEASE) && out_free;

	// lookahead on the second cell, or the result limit, marks the final release
	assign rel_last = !le[1] || (cnt_q == CW'(MAX_RESULTS - 1));

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_ent;
		entry_t right_ent;
		logic   left_le;
		if (i == 0) begin : g_first
			assign left_ent = '0;
			assign left_le  = 1'b1;
		end else begin : g_mid
			assign left_ent = ent[i-1];
			assign left_le  = le[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_ent = '0;
		end else begin : g_inner
			assign right_ent = ent[i+1];
		end
		ttcq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.new_ent   (new_ent),
			.left_ent  (left_ent),
			.left_le   (left_le),
			.right_ent (right_ent),
			.ent       (ent[i]),
			.le        (le[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			cnt_q      <= '0;
		end else begin
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (s_tuser[0] == OP_INSERT || !le[0]) begin
							m_tvalid_q <= 1'b1;
						end else begin
							state_q <= ST_RELEASE;
							cnt_q   <= '0;
						end
					end
				end
				ST_RELEASE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						cnt_q      <= cnt_q + CW'(1);
						if (rel_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_acc) begin
			rel_time_q <= s_tdata[31:0];
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b1;
			if (s_tuser[0] == OP_INSERT) begin
				m_tuser_q <= full ? KIND_FULL : KIND_ACCEPTED;
			end else begin
				m_tuser_q <= KIND_NONE_DUE;
			end
		end else if (cmd.pop) begin
			m_tdata_q <= {ent[0].command_tag, ent[0].subservice, ent[0].service,
				ent[0].time_tag};
			m_tuser_q <= KIND_RELEASED;
			m_tlast_q <= rel_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

FILE: tb/sv/time_tagged_command_queue_tb.sv
`timescale 1ns / 100ps

module time_tagged_command_queue_tb;
	import ttcq_pkg::*;

	localparam int          QDEPTH         = QUEUE_DEPTH_DEF;
	localparam int unsigned HOLD_AT        = 40;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned CALM_FROM      = 100;
	localparam int unsigned CALM_TO        = 140;
	localparam int unsigned IDLE_PCT       = 36;
	localparam int unsigned TAIL_CYCLES    = 40;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	typedef struct {
		logic        op;
		logic [31:0] tv;
		logic [7:0]  svc;
		logic [7:0]  sub;
		logic [15:0] tag;
		bit          wait_drain;
	} cmd_t;

	typedef struct {
		logic [31:0] t;
		logic [7:0]  svc;
		logic [7:0]  sub;
		logic [15:0] tag;
	} stored_cmd_t;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] t;
		logic [7:0]  svc;
		logic [7:0]  sub;
		logic [15:0] tag;
		logic        last;
	} outcome_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;
	logic [0:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	cmd_t        pending[$];
	outcome_t    awaited_outcomes[$];
	stored_cmd_t stored[QDEPTH];
	int unsigned held          = 0;
	int unsigned n_expected    = 0;
	int unsigned n_seen        = 0;
	int unsigned n_in_accepted = 0;
	int unsigned n_mismatch    = 0;
	int unsigned hold_left     = 0;
	bit          hold_armed    = 1'b1;
	int unsigned idle_cycles   = 0;
	logic        calm;

	assign calm = (n_in_accepted >= CALM_FROM) && (n_in_accepted < CALM_TO);

	time_tagged_command_queue #(
		.QUEUE_DEPTH(QDEPTH)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// updates the sorted store and queues the results one command causes
	function automatic int unsigned forecast_results(input cmd_t c);
		int unsigned pos;
		int unsigned due;
		int unsigned i;
		outcome_t    r;
		r      = '{default: '0};
		r.last = 1'b1;
		if (c.op == OP_INSERT) begin
			if (held >= QDEPTH) begin
				r.kind = KIND_FULL;
				awaited_outcomes.push_back(r);
				return 1;
			end
			// equal tags go behind the ones already stored
			pos = 0;
			while (pos < held && stored[pos].t <= c.tv)
				pos++;
			for (i = held; i > pos; i--)
				stored[i] = stored[i - 1];
			stored[pos] = '{t: c.tv, svc: c.svc, sub: c.sub, tag: c.tag};
			held++;
			r.kind = KIND_ACCEPTED;
			awaited_outcomes.push_back(r);
			return 1;
		end
		due = 0;
		while (due < held && due < MAX_RESULTS && stored[due].t <= c.tv)
			due++;
		if (due == 0) begin
			r.kind = KIND_NONE_DUE;
			awaited_outcomes.push_back(r);
			return 1;
		end
		for (i = 0; i < due; i++) begin
			r.kind = KIND_RELEASED;
			r.t    = stored[i].t;
			r.svc  = stored[i].svc;
			r.sub  = stored[i].sub;
			r.tag  = stored[i].tag;
			r.last = (i + 1 == due);
			awaited_outcomes.push_back(r);
		end
		for (i = due; i < held; i++)
			stored[i - due] = stored[i];
		held -= due;
		return due;
	endfunction

	task automatic enqueue_command(input logic op, input logic [31:0] tv,
			input logic [7:0] svc, input logic [7:0] sub, input logic [15:0] tag);
		pending.push_back('{op: op, tv: tv, svc: svc, sub: sub, tag: tag, wait_drain: 1'b0});
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			n_mismatch++;
			if (n_mismatch <= 10)
				$display("mismatch on result %0d, %s: expected %0h, got %0h",
					n_seen, field, want, got);
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin : sender
		int unsigned exp_now;
		logic        go;
		cmd_t        cur;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			exp_now = n_expected;
			go      = !s_tvalid;
			if (s_tvalid && s_tready) begin
				exp_now += forecast_results(cur);
				n_in_accepted <= n_in_accepted + 1;
				go = 1'b1;
			end
			n_expected <= exp_now;
			if (go) begin
				if (pending.size() != 0 && !(pending[0].wait_drain && n_seen != exp_now)
						&& (calm || $urandom_range(99) >= IDLE_PCT)) begin
					cur = pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {cur.tag, cur.sub, cur.svc, cur.tv};
					s_tuser  <= cur.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin : receiver
		outcome_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_seen <= n_seen + 1;
				if (awaited_outcomes.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("unexpected result %0d: kind %0h data %0h last %0b",
							n_seen, m_tuser, m_tdata, m_tlast);
				end else begin
					want = awaited_outcomes.pop_front();
					check_field("kind", 32'(want.kind), 32'(m_tuser));
					check_field("out_time", want.t, m_tdata[31:0]);
					check_field("out_service", 32'(want.svc), 32'(m_tdata[39:32]));
					check_field("out_subservice", 32'(want.sub), 32'(m_tdata[47:40]));
					check_field("out_tag", 32'(want.tag), 32'(m_tdata[63:48]));
					check_field("last", 32'(want.last), 32'(m_tlast));
				end
			end
			m_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
		end
	end

	// one long output stall so the queue backs up onto its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			hold_armed <= 1'b1;
		end else if (hold_armed && n_in_accepted == HOLD_AT) begin
			hold_left  <= HOLD_CYCLES;
			hold_armed <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned k;
		int unsigned n_rand;
		int unsigned roll;
		logic [31:0] now_t;
		logic [31:0] tv;

		// directed: empty release, field extremes, equal tags, fill to full, full flush
		enqueue_command(OP_RELEASE, 32'd0, 8'h00, 8'h00, 16'h0000);
		enqueue_command(OP_INSERT, 32'd0, 8'h00, 8'h00, 16'h0000);
		enqueue_command(OP_INSERT, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF);
		enqueue_command(OP_INSERT, 32'd5, 8'h01, 8'h02, 16'h1111);
		enqueue_command(OP_INSERT, 32'd5, 8'h03, 8'h04, 16'h2222);
		enqueue_command(OP_RELEASE, 32'd4, 8'hFF, 8'hFF, 16'hFFFF);
		enqueue_command(OP_RELEASE, 32'd5, 8'h00, 8'h00, 16'h0000);
		for (k = 0; k < QDEPTH - 1; k++)
			enqueue_command(OP_INSERT, (k == 7) ? 32'hFFFF_FFFF : 32'd100 - 7 * k,
				8'(k), 8'(255 - k), 16'(16'hA000 + k));
		enqueue_command(OP_INSERT, 32'd1, 8'h55, 8'hAA, 16'h5A5A);
		enqueue_command(OP_RELEASE, 32'hFFFF_FFFF, 8'h00, 8'h00, 16'h0000);

		// random: mostly tags close to a running clock so releases find due work
		now_t  = 32'd1000;
		n_rand = 0;
		while (n_rand < 106) begin
			roll = $urandom_range(99);
			if (roll < 5) begin
				for (k = 0; k < QDEPTH + 2; k++)
					enqueue_command(OP_INSERT, now_t + $urandom_range(40),
						8'($urandom), 8'($urandom), 16'($urandom));
				n_rand += QDEPTH + 2;
			end else if (roll < 55) begin
				tv = (roll < 12) ? $urandom : now_t + $urandom_range(30);
				enqueue_command(OP_INSERT, tv, 8'($urandom), 8'($urandom), 16'($urandom));
				n_rand++;
			end else begin
				now_t += $urandom_range(25);
				tv = (roll > 96) ? 32'hFFFF_FFFF : (roll > 93) ? $urandom : now_t;
				enqueue_command(OP_RELEASE, tv, 8'($urandom), 8'($urandom),
					16'($urandom));
				n_rand++;
			end
		end
		// sender waits here until every outstanding result has been seen
		pending[90].wait_drain = 1'b1;

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do
			@(negedge clk);
		while (pending.size() != 0 || s_tvalid || n_seen != n_expected);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (n_mismatch == 0 && awaited_outcomes.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
